@@ rtl/mmp_pkg.sv @@
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types, constants and the microcode table of the 128-bit
// preinverse modular multiplier.
// ----------------------------------------------------------------------------
package mmp_pkg;

  // Field and datapath widths
  localparam int unsigned LimbW    = 64;
  localparam int unsigned WideW    = 128;
  localparam int unsigned DigitW   = 32;
  localparam int unsigned ProdW    = 2 * DigitW;
  localparam int unsigned AccW     = 256;
  localparam int unsigned RemW     = 192;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned StepW    = 6;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned CfgDataW = 64;

  localparam int unsigned MaxCorrDefault = 4;

  // Register map, indexed by paddr[5:3]
  typedef enum logic [2:0] {
    REG_MOD_LO = 3'd0,
    REG_MOD_HI = 3'd1,
    REG_INV_LO = 3'd2,
    REG_INV_HI = 3'd3,
    REG_SHIFT  = 3'd4
  } reg_idx_e;

  // Microcode operations
  typedef enum logic [2:0] {
    OP_MAC   = 3'd0,  // multiply one digit pair, accumulate
    OP_NOP   = 3'd1,  // let the last product land in the accumulator
    OP_SAVEP = 3'd2,  // product a*b to p, clear accumulator
    OP_SETQ  = 3'd3,  // quotient estimate from accumulator and p
    OP_SUBR  = 3'd4,  // r = p - q*d over 192 bits
    OP_CORR  = 3'd5,  // subtract modulus while carry limb is nonzero
    OP_FIX   = 3'd6,  // final compare and subtract
    OP_OUT   = 3'd7   // shift back and load the result register
  } op_e;

  // Operand pair for OP_MAC
  typedef enum logic [1:0] {
    SRC_AB = 2'd0,    // a digit times b digit
    SRC_PI = 2'd1,    // top product digit times inverse digit
    SRC_QD = 2'd2     // quotient digit times modulus digit
  } src_e;

  typedef struct packed {
    op_e              op;
    src_e             src;
    logic [1:0]       xi;
    logic [1:0]       yj;
    logic [StepW-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic       load_in;
    op_e        op;
    src_e       src;
    logic [1:0] xi;
    logic [1:0] yj;
    logic       fire;
  } dp_ctrl_t;

  typedef struct packed {
    logic carry_nz;
  } dp_stat_t;

  typedef struct packed {
    logic [WideW-1:0]  modulus;
    logic [WideW-1:0]  inverse;
    logic [ShiftW-1:0] shift;
  } cfg_t;

  // Program layout
  localparam logic [StepW-1:0] MulLen  = 6'd16;
  localparam logic [StepW-1:0] PcMulAb = 6'd0;
  localparam logic [StepW-1:0] PcNopAb = 6'd16;
  localparam logic [StepW-1:0] PcSaveP = 6'd17;
  localparam logic [StepW-1:0] PcMulPi = 6'd18;
  localparam logic [StepW-1:0] PcNopPi = 6'd34;
  localparam logic [StepW-1:0] PcSetQ  = 6'd35;
  localparam logic [StepW-1:0] PcMulQd = 6'd36;
  localparam logic [StepW-1:0] PcNopQd = 6'd52;
  localparam logic [StepW-1:0] PcSubR  = 6'd53;
  localparam logic [StepW-1:0] PcCorr  = 6'd54;
  localparam logic [StepW-1:0] PcFix   = 6'd55;
  localparam logic [StepW-1:0] PcOut   = 6'd56;

  // Microcode ROM: one control word per step
  function automatic uword_t ucode_rom(input logic [StepW-1:0] pc);
    uword_t           w;
    logic [StepW-1:0] k;
    w     = '0;
    w.op  = OP_NOP;
    w.src = SRC_AB;
    k     = '0;
    if (pc < PcMulAb + MulLen) begin
      k     = pc - PcMulAb;
      w.op  = OP_MAC;
      w.src = SRC_AB;
    end else if (pc >= PcMulPi && pc < PcMulPi + MulLen) begin
      k     = pc - PcMulPi;
      w.op  = OP_MAC;
      w.src = SRC_PI;
    end else if (pc >= PcMulQd && pc < PcMulQd + MulLen) begin
      k     = pc - PcMulQd;
      w.op  = OP_MAC;
      w.src = SRC_QD;
    end else if (pc == PcNopAb || pc == PcNopPi || pc == PcNopQd) begin
      w.op = OP_NOP;
    end else if (pc == PcSaveP) begin
      w.op = OP_SAVEP;
    end else if (pc == PcSetQ) begin
      w.op = OP_SETQ;
    end else if (pc == PcSubR) begin
      w.op = OP_SUBR;
    end else if (pc == PcCorr) begin
      w.op  = OP_CORR;
      w.tgt = PcCorr;
    end else if (pc == PcFix) begin
      w.op = OP_FIX;
    end else begin
      w.op = OP_OUT;
    end
    w.xi = k[3:2];
    w.yj = k[1:0];
    return w;
  endfunction

endpackage

@@ rtl/mmp_if.sv @@
// ----------------------------------------------------------------------------
// mmp_if
// Valid/ready channels for factor pairs and reduced products.
// ----------------------------------------------------------------------------
interface mmp_item_if;
  import mmp_pkg::*;

  logic             valid;
  logic             ready;
  logic [LimbW-1:0] a_low;
  logic [LimbW-1:0] a_high;
  logic [LimbW-1:0] b_low;
  logic [LimbW-1:0] b_high;

  modport source (output valid, a_low, a_high, b_low, b_high, input ready);
  modport sink   (input valid, a_low, a_high, b_low, b_high, output ready);
endinterface

interface mmp_res_if;
  import mmp_pkg::*;

  logic             valid;
  logic             ready;
  logic [LimbW-1:0] rem_low;
  logic [LimbW-1:0] rem_high;
  logic             overrun;

  modport source (output valid, rem_low, rem_high, overrun, input ready);
  modport sink   (input valid, rem_low, rem_high, overrun, output ready);
endinterface

@@ rtl/mmp_cfg.sv @@
// ----------------------------------------------------------------------------
// mmp_cfg
// APB register file: modulus, inverse and normalization shift.
// ----------------------------------------------------------------------------
module mmp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmp_pkg::AddrW-1:0]     paddr,
  input  logic [mmp_pkg::CfgDataW-1:0]  pwdata,
  output logic [mmp_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output mmp_pkg::cfg_t                 cfg_o
);
  import mmp_pkg::*;

  logic [LimbW-1:0]  mod_lo_q, mod_hi_q, inv_lo_q, inv_hi_q;
  logic [ShiftW-1:0] shift_q;
  reg_idx_e          idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:3]);
  assign wr_en  = psel & penable & pwrite;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_lo_q <= '0;
      mod_hi_q <= {1'b1, {(LimbW-1){1'b0}}};
      inv_lo_q <= '0;
      inv_hi_q <= '0;
      shift_q  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MOD_LO: mod_lo_q <= pwdata;
        REG_MOD_HI: mod_hi_q <= pwdata;
        REG_INV_LO: inv_lo_q <= pwdata;
        REG_INV_HI: inv_hi_q <= pwdata;
        REG_SHIFT:  shift_q  <= pwdata[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_MOD_LO: prdata = mod_lo_q;
      REG_MOD_HI: prdata = mod_hi_q;
      REG_INV_LO: prdata = inv_lo_q;
      REG_INV_HI: prdata = inv_hi_q;
      REG_SHIFT:  prdata = {{(CfgDataW-ShiftW){1'b0}}, shift_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.modulus = {mod_hi_q, mod_lo_q};
  assign cfg_o.inverse = {inv_hi_q, inv_lo_q};
  assign cfg_o.shift   = shift_q;

endmodule

@@ rtl/mmp_seq.sv @@
// ----------------------------------------------------------------------------
// mmp_seq
// Microcode sequencer: step counter, control ROM, correction loop counter
// and the input/output handshakes.
// ----------------------------------------------------------------------------
module mmp_seq #(
  parameter int unsigned MAX_CORRECTIONS = mmp_pkg::MaxCorrDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mmp_pkg::dp_stat_t   stat_i,
  output mmp_pkg::dp_ctrl_t   ctrl_o
);
  import mmp_pkg::*;

  localparam int unsigned     CntW = $clog2(MAX_CORRECTIONS + 1);
  localparam logic [CntW-1:0] NMax = CntW'(MAX_CORRECTIONS);

  logic             busy_q, busy_d;
  logic             oval_q, oval_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  corr_q, corr_d;
  uword_t           word;
  logic             accept;

  assign word        = ucode_rom(step_q);
  assign in_ready_o  = ~busy_q;
  assign accept      = in_valid_i & ~busy_q;
  assign out_valid_o = oval_q;

  // Step through the program; loop on the correction step
  always_comb begin
    busy_d = busy_q;
    oval_d = oval_q;
    step_d = step_q;
    corr_d = corr_q;

    ctrl_o.load_in = accept;
    ctrl_o.op      = busy_q ? word.op : OP_NOP;
    ctrl_o.src     = word.src;
    ctrl_o.xi      = word.xi;
    ctrl_o.yj      = word.yj;
    ctrl_o.fire    = 1'b0;

    // drop the result once transferred
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end

    if (busy_q) begin
      unique case (word.op)
        OP_CORR: begin
          if (stat_i.carry_nz && corr_q != NMax) begin
            ctrl_o.fire = 1'b1;
            corr_d      = corr_q + 1'b1;
            step_d      = word.tgt;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        OP_OUT: begin
          // hold until the result register is free
          if (!oval_q || out_ready_i) begin
            ctrl_o.fire = 1'b1;
            oval_d      = 1'b1;
            busy_d      = 1'b0;
          end
        end
        default: step_d = step_q + 1'b1;
      endcase
    end else if (accept) begin
      busy_d = 1'b1;
      step_d = '0;
      corr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
      step_q <= '0;
      corr_q <= '0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
      step_q <= step_d;
      corr_q <= corr_d;
    end
  end

endmodule

@@ rtl/mmp_dp.sv @@
// ----------------------------------------------------------------------------
// mmp_dp
// Datapath: 32x32 multiplier with product register, 256-bit accumulator,
// quotient and remainder registers, result register.
// ----------------------------------------------------------------------------
module mmp_dp (
  input  logic                       clk_i,
  input  mmp_pkg::dp_ctrl_t          ctrl_i,
  input  mmp_pkg::cfg_t              cfg_i,
  input  logic [mmp_pkg::LimbW-1:0]  a_low_i,
  input  logic [mmp_pkg::LimbW-1:0]  a_high_i,
  input  logic [mmp_pkg::LimbW-1:0]  b_low_i,
  input  logic [mmp_pkg::LimbW-1:0]  b_high_i,
  output mmp_pkg::dp_stat_t          stat_o,
  output logic [mmp_pkg::LimbW-1:0]  rem_low_o,
  output logic [mmp_pkg::LimbW-1:0]  rem_high_o,
  output logic                       overrun_o
);
  import mmp_pkg::*;

  logic [WideW-1:0]  a_q, b_q, q_q, q_d;
  logic [AccW-1:0]   p_q, p_d, acc_q, acc_d, addend;
  logic [RemW-1:0]   r_q, r_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [2:0]        psh_q;
  logic              pvld_q;
  logic              ovf_q, ovf_d;
  logic [WideW-1:0]  rem_q, rem_d;
  logic              rover_q, rover_d;
  logic [DigitW-1:0] x_dig, y_dig;
  logic [WideW-1:0]  x_src, y_src;

  // Pick the digit pair for this step
  always_comb begin
    unique case (ctrl_i.src)
      SRC_AB: begin
        x_src = a_q;
        y_src = b_q;
      end
      SRC_PI: begin
        x_src = p_q[AccW-1:WideW];
        y_src = cfg_i.inverse;
      end
      SRC_QD: begin
        x_src = q_q;
        y_src = cfg_i.modulus;
      end
      default: begin
        x_src = a_q;
        y_src = b_q;
      end
    endcase
    x_dig = x_src[{ctrl_i.xi, 5'd0} +: DigitW];
    y_dig = y_src[{ctrl_i.yj, 5'd0} +: DigitW];
  end

  assign prod_d = {{(ProdW-DigitW){1'b0}}, x_dig} * {{(ProdW-DigitW){1'b0}}, y_dig};
  assign addend = {{(AccW-ProdW){1'b0}}, prod_q} << {psh_q, 5'd0};

  assign stat_o.carry_nz = |r_q[RemW-1:WideW];

  // Accumulate, then run the reduction step named by the control word
  always_comb begin
    acc_d   = pvld_q ? acc_q + addend : acc_q;
    p_d     = p_q;
    q_d     = q_q;
    r_d     = r_q;
    ovf_d   = ovf_q;
    rem_d   = rem_q;
    rover_d = rover_q;
    unique case (ctrl_i.op)
      OP_SAVEP: begin
        p_d   = acc_q;
        acc_d = '0;
      end
      OP_SETQ: begin
        q_d   = acc_q[AccW-1:WideW] + p_q[AccW-1:WideW];
        acc_d = '0;
      end
      OP_SUBR: r_d = p_q[RemW-1:0] - acc_q[RemW-1:0];
      OP_CORR: begin
        if (ctrl_i.fire) begin
          r_d = r_q - {{(RemW-WideW){1'b0}}, cfg_i.modulus};
        end else begin
          ovf_d = stat_o.carry_nz;
        end
      end
      OP_FIX: begin
        if (r_q[WideW-1:0] >= cfg_i.modulus) begin
          r_d[WideW-1:0] = r_q[WideW-1:0] - cfg_i.modulus;
        end
      end
      OP_OUT: begin
        if (ctrl_i.fire) begin
          rem_d   = r_q[WideW-1:0] >> cfg_i.shift;
          rover_d = ovf_q;
        end
      end
      default: ;
    endcase
    if (ctrl_i.load_in) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      a_q <= {a_high_i, a_low_i};
      b_q <= {b_high_i, b_low_i} << cfg_i.shift;
    end
    prod_q  <= prod_d;
    psh_q   <= {1'b0, ctrl_i.xi} + {1'b0, ctrl_i.yj};
    acc_q   <= acc_d;
    p_q     <= p_d;
    q_q     <= q_d;
    r_q     <= r_d;
    ovf_q   <= ovf_d;
    rem_q   <= rem_d;
    rover_q <= rover_d;
  end

  // Product-valid flag is control state
  always_ff @(posedge clk_i) begin
    pvld_q <= (ctrl_i.op == OP_MAC);
  end

  assign rem_low_o  = rem_q[LimbW-1:0];
  assign rem_high_o = rem_q[WideW-1:LimbW];
  assign overrun_o  = rover_q;

endmodule

@@ rtl/mulmod_preinverse_128.sv @@
// ----------------------------------------------------------------------------
// mulmod_preinverse_128
// 128-bit modular multiply with precomputed inverse, microcoded over one
// 32x32 multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------
//  item_i   | in  | valid/ready        | a_low, a_high, b_low, b_high
//  res_o    | out | valid/ready        | rem_low, rem_high, overrun
//  apb      | in  | psel/penable/pready| paddr, pwdata, prdata (64 bits)
//
// One item occupies the block for the whole microcode program plus n
// modulus subtractions in the correction loop (0 to MAX_CORRECTIONS); the
// next item can be taken in the cycle after the final step fires. The
// run length is set by the 48 digit products through the single multiplier.
// Reset clears the sequencer and loads the register reset values; no
// clearing pass is needed. A result waiting on res_o does not block the
// next item; only the final step stalls until the result register is free.
// ----------------------------------------------------------------------------
module mulmod_preinverse_128 #(
  parameter int unsigned MAX_CORRECTIONS = mmp_pkg::MaxCorrDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mmp_item_if.sink                      item_i,
  mmp_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmp_pkg::AddrW-1:0]     paddr,
  input  logic [mmp_pkg::CfgDataW-1:0]  pwdata,
  output logic [mmp_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import mmp_pkg::*;

  cfg_t     cfg;
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  mmp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mmp_seq #(
    .MAX_CORRECTIONS (MAX_CORRECTIONS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mmp_dp u_dp (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg),
    .a_low_i    (item_i.a_low),
    .a_high_i   (item_i.a_high),
    .b_low_i    (item_i.b_low),
    .b_high_i   (item_i.b_high),
    .stat_o     (stat),
    .rem_low_o  (res_o.rem_low),
    .rem_high_o (res_o.rem_high),
    .overrun_o  (res_o.overrun)
  );

  // Block goes busy after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("input still ready after a transfer");

  // A new result only appears at the end of a busy stretch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(!item_i.ready))
    else $error("result appeared while idle");

  // No result in the cycle right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !$rose(res_o.valid))
    else $error("result too early after transfer in");

endmodule
